// ===== src/transposition_key_index_mapper_macros.svh =====
// Assertion helpers for the key index mapper.
`ifndef TRANSPOSITION_KEY_INDEX_MAPPER_MACROS_SVH
`define TRANSPOSITION_KEY_INDEX_MAPPER_MACROS_SVH

// same-cycle implication
`define TKIM_CHK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TKIM_CHK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tkim_pkg.sv =====
package tkim_pkg;

	localparam int MAX_SIDE_DEF = 256;

	localparam int LEN_W  = 17;
	localparam int SEED_W = 31;
	localparam int IDX_W  = 16;
	localparam int OUT_W  = 17;
	localparam int REQ_W  = 2;
	localparam int STAT_W = 2;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam int MUL_W  = 15;

	localparam logic [SEED_W-1:0] LCG_MOD = 31'h7FFF_FFFF;
	localparam logic [MUL_W-1:0]  LCG_MUL = 15'd16807;

	localparam logic [REQ_W-1:0] REQ_BUILD = 2'd0;
	localparam logic [REQ_W-1:0] REQ_FWD   = 2'd1;
	localparam logic [REQ_W-1:0] REQ_INV   = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_RANGE     = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOT_BUILT = 2'd2;

	localparam logic [ADDR_W-1:0] REG_FILE_LEN = 3'd0;
	localparam logic [ADDR_W-1:0] REG_SEED     = 3'd4;

	typedef enum logic [4:0] {
		S_IDLE, S_CHECK, S_SQRT, S_SIDE, S_INIT, S_SHCHK, S_LCG_MUL, S_LCG_RED,
		S_DIV_GO, S_DIV_WAIT, S_RD_A, S_RD_B, S_WR_A, S_WR_B, S_INV_RD, S_INV_WR,
		S_MAP_GO, S_MAP_WAIT, S_MAP_RD, S_MAP_MUL, S_DONE
	} state_t;

	typedef enum logic [4:0] {
		OP_NOP, OP_LOAD, OP_CHECK, OP_SQRT, OP_SIDE, OP_INIT, OP_NEXT_TAB,
		OP_LCG_MUL, OP_LCG_RED, OP_DIV_GO, OP_DIV_TAKE, OP_RD_A, OP_RD_B,
		OP_WR_A, OP_WR_B, OP_INV_START, OP_INV_RD, OP_INV_WR, OP_BUILT_RES,
		OP_MAP_GO, OP_MAP_RD, OP_MAP_MUL
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   push;
	} cmd_t;

	typedef struct packed {
		logic build_req;
		logic map_req;
		logic drop_req;
		logic built;
		logic result_bad;
		logic sqrt_more;
		logic cnt_lt_side;
		logic cnt_gt_one;
		logic tsel_col;
		logic div_done;
	} sts_t;

endpackage

// ===== src/tkim_if.sv =====
interface tkim_req_if;
	import tkim_pkg::*;
	logic               valid;
	logic               ready;
	logic [REQ_W-1:0]   req_type;
	logic [IDX_W-1:0]   item_index;
	modport source(output valid, output req_type, output item_index, input ready);
	modport sink(input valid, input req_type, input item_index, output ready);
endinterface

interface tkim_rsp_if;
	import tkim_pkg::*;
	logic               valid;
	logic               ready;
	logic [OUT_W-1:0]   mapped_index;
	logic [STAT_W-1:0]  status;
	modport source(output valid, output mapped_index, output status, input ready);
	modport sink(input valid, input mapped_index, input status, output ready);
endinterface

// ===== src/tkim_div.sv =====
module tkim_div import tkim_pkg::*; #(
	parameter int DW = SEED_W,
	parameter int VW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot,
	output logic [VW-1:0] rem
);

	localparam int CNT_W = $clog2(DW + 1);

	logic [VW-1:0]    rem_q;
	logic [DW-1:0]    quo_q;
	logic [VW-1:0]    dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [VW:0]      trial;
	logic             fits;

	assign trial = {rem_q, quo_q[DW-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? VW'(trial - {1'b0, dsr_q}) : trial[VW-1:0];
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

// ===== src/tkim_ctrl.sv =====
module tkim_ctrl import tkim_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.push)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (in_valid) state_d = S_CHECK;
			S_CHECK: begin
				if (sts.drop_req)
					state_d = S_IDLE;
				else if (sts.build_req)
					state_d = S_SQRT;
				else if (sts.result_bad)
					state_d = S_DONE;
				else
					state_d = S_MAP_GO;
			end
			S_SQRT:     if (!sts.sqrt_more) state_d = S_SIDE;
			S_SIDE:     state_d = S_INIT;
			S_INIT:     if (!sts.cnt_lt_side) state_d = S_SHCHK;
			S_SHCHK: begin
				if (sts.cnt_gt_one)
					state_d = S_LCG_MUL;
				else if (!sts.tsel_col)
					state_d = S_INIT;
				else
					state_d = S_INV_RD;
			end
			S_LCG_MUL:  state_d = S_LCG_RED;
			S_LCG_RED:  state_d = S_DIV_GO;
			S_DIV_GO:   state_d = S_DIV_WAIT;
			S_DIV_WAIT: if (sts.div_done) state_d = S_RD_A;
			S_RD_A:     state_d = S_RD_B;
			S_RD_B:     state_d = S_WR_A;
			S_WR_A:     state_d = S_WR_B;
			S_WR_B:     state_d = S_SHCHK;
			S_INV_RD:   state_d = sts.cnt_lt_side ? S_INV_WR : S_DONE;
			S_INV_WR:   state_d = S_INV_RD;
			S_MAP_GO:   state_d = S_MAP_WAIT;
			S_MAP_WAIT: if (sts.div_done) state_d = S_MAP_RD;
			S_MAP_RD:   state_d = S_MAP_MUL;
			S_MAP_MUL:  state_d = S_DONE;
			S_DONE:     if (slot_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.op   = OP_NOP;
		cmd.push = 1'b0;
		case (state_q)
			S_IDLE:     if (in_valid) cmd.op = OP_LOAD;
			S_CHECK:    cmd.op = OP_CHECK;
			S_SQRT:     cmd.op = OP_SQRT;
			S_SIDE:     cmd.op = OP_SIDE;
			S_INIT:     cmd.op = OP_INIT;
			S_SHCHK: begin
				if (!sts.cnt_gt_one)
					cmd.op = sts.tsel_col ? OP_INV_START : OP_NEXT_TAB;
			end
			S_LCG_MUL:  cmd.op = OP_LCG_MUL;
			S_LCG_RED:  cmd.op = OP_LCG_RED;
			S_DIV_GO:   cmd.op = OP_DIV_GO;
			S_DIV_WAIT: if (sts.div_done) cmd.op = OP_DIV_TAKE;
			S_RD_A:     cmd.op = OP_RD_A;
			S_RD_B:     cmd.op = OP_RD_B;
			S_WR_A:     cmd.op = OP_WR_A;
			S_WR_B:     cmd.op = OP_WR_B;
			S_INV_RD:   cmd.op = sts.cnt_lt_side ? OP_INV_RD : OP_BUILT_RES;
			S_INV_WR:   cmd.op = OP_INV_WR;
			S_MAP_GO:   cmd.op = OP_MAP_GO;
			S_MAP_RD:   cmd.op = OP_MAP_RD;
			S_MAP_MUL:  cmd.op = OP_MAP_MUL;
			S_DONE:     cmd.push = slot_free;
			default:    cmd.op = OP_NOP;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// ===== src/tkim_datapath.sv =====
module tkim_datapath import tkim_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF,
	parameter int SW = $clog2(MAX_SIDE + 1),
	parameter int IW = $clog2(MAX_SIDE)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [REQ_W-1:0]  in_req_type,
	input  logic [IDX_W-1:0]  in_item_index,
	input  logic [LEN_W-1:0]  file_length,
	input  logic [SEED_W-1:0] rng_seed,
	output logic              div_start,
	output logic [SEED_W-1:0] div_dividend,
	output logic [SW-1:0]     div_divisor,
	input  logic              div_done,
	input  logic [SEED_W-1:0] div_quot,
	input  logic [SW-1:0]     div_rem,
	output logic [OUT_W-1:0]  out_mapped_index,
	output logic [STAT_W-1:0] out_status
);

	localparam int RT_W   = 10;
	localparam int SQ_W   = 20;
	localparam int PROD_W = SEED_W + MUL_W;
	localparam int MW     = (IW + SW + 1 > OUT_W) ? IW + SW + 1 : OUT_W;

	// control registers
	logic              built_q;
	logic              tsel_col_q;
	// payload registers
	logic [REQ_W-1:0]  req_q;
	logic [IDX_W-1:0]  idx_q;
	logic [RT_W-1:0]   s_q;
	logic [SQ_W-1:0]   sq_q;
	logic [SW-1:0]     side_q;
	logic [2*SW-1:0]   seq_q;
	logic [SW-1:0]     cnt_q;
	logic [IW-1:0]     j_q;
	logic [IW-1:0]     a_q;
	logic [SEED_W-1:0] lcg_q;
	logic [PROD_W-1:0] prod_s1;
	logic [OUT_W-1:0]  res_idx_q;
	logic [STAT_W-1:0] res_st_q;
	logic [OUT_W-1:0]  out_idx_q;
	logic [STAT_W-1:0] out_st_q;

	// tables
	logic [IW-1:0] rp_mem [MAX_SIDE];
	logic [IW-1:0] cp_mem [MAX_SIDE];
	logic [IW-1:0] ri_mem [MAX_SIDE];
	logic [IW-1:0] ci_mem [MAX_SIDE];
	logic [IW-1:0] rp_rd_q, cp_rd_q, ri_rd_q, ci_rd_q;

	logic [SQ_W-1:0]   sq_nxt;
	logic              range_bad;
	logic [RT_W-1:0]   s_ceil;
	logic [SEED_W:0]   lcg_sum;
	logic [IW-1:0]     cnt_lo, cnt_m1, sh_addr, sh_wdata, act_rd;
	logic [IW-1:0]     rp_addr, cp_addr, ri_addr, ci_addr;
	logic              sh_we, rp_we, cp_we, inv_we;
	logic [IW-1:0]     q_lo, r_lo, pr, pc;
	logic [MW-1:0]     map_val;

	assign sq_nxt    = sq_q + SQ_W'({s_q, 1'b0}) + SQ_W'(1);
	assign range_bad = (side_q == '0) || (32'(idx_q) >= 32'(seq_q));
	assign s_ceil    = s_q + RT_W'(sq_q < SQ_W'(file_length));
	assign lcg_sum   = (SEED_W + 1)'(prod_s1[SEED_W-1:0])
	                 + (SEED_W + 1)'(prod_s1[PROD_W-1:SEED_W]);

	assign cnt_lo = cnt_q[IW-1:0];
	assign cnt_m1 = IW'(cnt_q - 1'b1);
	assign q_lo   = div_quot[IW-1:0];
	assign r_lo   = div_rem[IW-1:0];
	assign act_rd = tsel_col_q ? cp_rd_q : rp_rd_q;

	always_comb begin
		case (cmd.op)
			OP_RD_A, OP_WR_A: sh_addr = cnt_m1;
			OP_RD_B, OP_WR_B: sh_addr = j_q;
			default:          sh_addr = cnt_lo;
		endcase
		case (cmd.op)
			OP_WR_A: sh_wdata = act_rd;
			OP_WR_B: sh_wdata = a_q;
			default: sh_wdata = cnt_lo;
		endcase
		sh_we = (cmd.op == OP_INIT && sts.cnt_lt_side)
		     || cmd.op == OP_WR_A || cmd.op == OP_WR_B;
		rp_we  = sh_we && !tsel_col_q;
		cp_we  = sh_we && tsel_col_q;
		inv_we = (cmd.op == OP_INV_WR);
		case (cmd.op)
			OP_MAP_RD:  begin rp_addr = q_lo;   cp_addr = r_lo;   end
			OP_INV_RD:  begin rp_addr = cnt_lo; cp_addr = cnt_lo; end
			default:    begin rp_addr = sh_addr; cp_addr = sh_addr; end
		endcase
		ri_addr = inv_we ? rp_rd_q : q_lo;
		ci_addr = inv_we ? cp_rd_q : r_lo;
	end

	always_ff @(posedge clk) begin
		if (rp_we) rp_mem[rp_addr] <= sh_wdata;
		rp_rd_q <= rp_mem[rp_addr];
	end
	always_ff @(posedge clk) begin
		if (cp_we) cp_mem[cp_addr] <= sh_wdata;
		cp_rd_q <= cp_mem[cp_addr];
	end
	always_ff @(posedge clk) begin
		if (inv_we) ri_mem[ri_addr] <= cnt_lo;
		ri_rd_q <= ri_mem[ri_addr];
	end
	always_ff @(posedge clk) begin
		if (inv_we) ci_mem[ci_addr] <= cnt_lo;
		ci_rd_q <= ci_mem[ci_addr];
	end

	assign pr      = (req_q == REQ_FWD) ? rp_rd_q : ri_rd_q;
	assign pc      = (req_q == REQ_FWD) ? cp_rd_q : ci_rd_q;
	assign map_val = MW'(pr) * MW'(side_q) + MW'(pc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			built_q    <= 1'b0;
			tsel_col_q <= 1'b0;
			side_q     <= '0;
			lcg_q      <= SEED_W'(1);
		end else begin
			case (cmd.op)
				OP_CHECK:     tsel_col_q <= 1'b0;
				OP_SIDE:      side_q <= (int'(s_ceil) > MAX_SIDE) ? SW'(MAX_SIDE) : SW'(s_ceil);
				OP_NEXT_TAB:  tsel_col_q <= 1'b1;
				OP_BUILT_RES: built_q <= 1'b1;
				default:      ;
			endcase
			if (cmd.op == OP_CHECK && req_q == REQ_BUILD)
				lcg_q <= (rng_seed == LCG_MOD || rng_seed == '0) ? SEED_W'(1) : rng_seed;
			else if (cmd.op == OP_LCG_RED)
				lcg_q <= (lcg_sum >= (SEED_W + 1)'(LCG_MOD))
				       ? SEED_W'(lcg_sum - (SEED_W + 1)'(LCG_MOD)) : SEED_W'(lcg_sum);
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				req_q <= in_req_type;
				idx_q <= in_item_index;
			end
			OP_CHECK: begin
				s_q       <= '0;
				sq_q      <= '0;
				res_idx_q <= '0;
				res_st_q  <= !built_q ? ST_NOT_BUILT : (range_bad ? ST_RANGE : ST_OK);
			end
			OP_SQRT: begin
				if (sts.sqrt_more) begin
					s_q  <= s_q + 1'b1;
					sq_q <= sq_nxt;
				end
			end
			OP_SIDE, OP_NEXT_TAB, OP_INV_START: cnt_q <= '0;
			OP_INIT:      if (sts.cnt_lt_side) cnt_q <= cnt_q + 1'b1;
			OP_LCG_MUL:   prod_s1 <= PROD_W'(lcg_q) * PROD_W'(LCG_MUL);
			OP_DIV_TAKE:  j_q <= r_lo;
			OP_RD_B:      a_q <= act_rd;
			OP_WR_B:      cnt_q <= cnt_q - 1'b1;
			OP_INV_WR:    cnt_q <= cnt_q + 1'b1;
			OP_BUILT_RES: begin
				res_idx_q <= OUT_W'(seq_q);
				res_st_q  <= ST_OK;
			end
			OP_MAP_MUL:   res_idx_q <= map_val[OUT_W-1:0];
			default:      ;
		endcase
		if (cmd.op == OP_INV_START)
			seq_q <= (2 * SW)'(side_q) * (2 * SW)'(side_q);
		if (cmd.push) begin
			out_idx_q <= res_idx_q;
			out_st_q  <= res_st_q;
		end
	end

	assign div_start    = (cmd.op == OP_DIV_GO) || (cmd.op == OP_MAP_GO);
	assign div_dividend = (cmd.op == OP_MAP_GO) ? SEED_W'(idx_q) : lcg_q;
	assign div_divisor  = (cmd.op == OP_MAP_GO) ? side_q : cnt_q;

	always_comb begin
		sts.build_req   = (req_q == REQ_BUILD);
		sts.map_req     = (req_q == REQ_FWD) || (req_q == REQ_INV);
		sts.drop_req    = !sts.build_req && !sts.map_req;
		sts.built       = built_q;
		sts.result_bad  = !built_q || range_bad;
		sts.sqrt_more   = (sq_nxt <= SQ_W'(file_length)) && (int'(s_q) < MAX_SIDE);
		sts.cnt_lt_side = cnt_q < side_q;
		sts.cnt_gt_one  = cnt_q > SW'(1);
		sts.tsel_col    = tsel_col_q;
		sts.div_done    = div_done;
	end

	assign out_mapped_index = out_idx_q;
	assign out_status       = out_st_q;

endmodule

// ===== src/transposition_key_index_mapper.sv =====
// Channel  Dir  Payload                              Transaction
// req      in   req_type[1:0], item_index[15:0]      valid && ready
// rsp      out  mapped_index[16:0], status[1:0]      valid && ready
// apb      in   file_length @0x0, rng_seed @0x4      psel && penable && pwrite
//
// One request at a time. A map raises rsp.valid once the 31-step shared restoring
// divider has split the index, the tables have been read and the output register is
// free; a build runs one divider pass per Fisher-Yates swap.
// req.ready is high only while idle; a finished result waits in the output
// register, and the next request is taken while it waits.
// Reset clears control state; the tables hold garbage until the first build.
module transposition_key_index_mapper import tkim_pkg::*; #(
	parameter int MAX_SIDE = MAX_SIDE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	tkim_req_if.sink          req,
	tkim_rsp_if.source        rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	`include "transposition_key_index_mapper_macros.svh"

	localparam int SW = $clog2(MAX_SIDE + 1);
	localparam int IW = $clog2(MAX_SIDE);

	logic [LEN_W-1:0]  file_length_q;
	logic [SEED_W-1:0] rng_seed_q;
	logic              apb_wr;

	cmd_t              cmd;
	sts_t              sts;
	logic              div_start, div_done;
	logic [SEED_W-1:0] div_dividend, div_quot;
	logic [SW-1:0]     div_divisor, div_rem;

	// config registers, decoded on the word select bit
	assign apb_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_length_q <= '0;
			rng_seed_q    <= SEED_W'(1);
		end else if (apb_wr) begin
			if (paddr[2] == REG_SEED[2])
				rng_seed_q <= pwdata[SEED_W-1:0];
			else
				file_length_q <= pwdata[LEN_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_FILE_LEN[2]) ? DATA_W'(file_length_q)
	                                              : DATA_W'(rng_seed_q);

	tkim_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	tkim_datapath #(
		.MAX_SIDE (MAX_SIDE),
		.SW       (SW),
		.IW       (IW)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_req_type      (req.req_type),
		.in_item_index    (req.item_index),
		.file_length      (file_length_q),
		.rng_seed         (rng_seed_q),
		.div_start        (div_start),
		.div_dividend     (div_dividend),
		.div_divisor      (div_divisor),
		.div_done         (div_done),
		.div_quot         (div_quot),
		.div_rem          (div_rem),
		.out_mapped_index (rsp.mapped_index),
		.out_status       (rsp.status)
	);

	// shared by the swap index (lcg % i) and the row/column split
	tkim_div #(
		.DW (SEED_W),
		.VW (SW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	`TKIM_CHK_NOW(a_div_nonzero, div_start, div_divisor != '0, "divider started with zero divisor")
	`TKIM_CHK_NOW(a_err_zero, rsp.valid && rsp.status != ST_OK, rsp.mapped_index == '0, "error result carries nonzero index")
	`TKIM_CHK_NEXT(a_one_at_a_time, req.valid && req.ready, !req.ready, "request taken while busy")
	`TKIM_CHK_NEXT(a_built_sticky, sts.built, sts.built, "keys_built dropped")

endmodule

// ===== test/tb_transposition_key_index_mapper.sv =====
`default_nettype none

module tb_transposition_key_index_mapper;
	timeunit 1ns;
	timeprecision 1ps;

	import tkim_pkg::*;

	// req_type 3 is not a request: the block drops it without a result
	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam int WDOG_LIMIT   = 100000; // long enough for a full-size build
	localparam int SETTLE_CYC   = 60;     // outlasts a map, covers a dropped request
	localparam int N_DIR        = 28;
	localparam int N_PHASE      = 4;
	localparam int ITEMS_PHASE  = 345;
	localparam int LONG_HOLD    = 500;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t         kind;
		logic [REQ_W-1:0]  req;
		logic [IDX_W-1:0]  idx;
		logic [LEN_W-1:0]  len;
		logic [SEED_W-1:0] seed;
		logic              typed;     // expected result given in the row itself
		logic [OUT_W-1:0]  exp_idx;
		logic [STAT_W-1:0] exp_st;
	} dir_row_t;

	typedef struct packed {
		logic [OUT_W-1:0]  mapped;
		logic [STAT_W-1:0] status;
	} map_result_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata, prdata;

	tkim_req_if req_ch();
	tkim_rsp_if rsp_ch();

	transposition_key_index_mapper DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// ---------------------------------------------------------------
	// Shadow copy of the key tables and registers
	// ---------------------------------------------------------------
	logic [LEN_W-1:0]  cfg_len;
	logic [SEED_W-1:0] cfg_seed;
	bit   [7:0] row_key [256];
	bit   [7:0] col_key [256];
	bit   [7:0] row_unkey [256];
	bit   [7:0] col_unkey [256];
	int unsigned key_side;
	logic [SEED_W-1:0] shuffle_rng;
	bit keys_ready;

	map_result_t pending_maps[$];

	int src_idle_pct;
	int snk_stall_pct;
	int hold_cycles;
	int err_cnt;

	function automatic int unsigned side_of_len(int unsigned n);
		int unsigned s;
		s = 0;
		while ((s + 1) * (s + 1) <= n)
			s++;
		if (s * s < n)
			s++;
		return (s > 256) ? 256 : s;
	endfunction

	// Fisher-Yates walk from the top, LCG draws one swap partner per step
	task automatic shuffle_perm(output bit [7:0] t [256], input int unsigned n);
		int unsigned i, j;
		bit [7:0] tmp;
		for (i = 0; i < n; i++)
			t[i] = i[7:0];
		for (i = n; i > 1; i--) begin
			shuffle_rng = SEED_W'((64'(shuffle_rng) * 64'd16807) % 64'h7FFF_FFFF);
			j = shuffle_rng % i;
			tmp = t[i-1];
			t[i-1] = t[j];
			t[j] = tmp;
		end
	endtask

	task automatic rebuild_keys();
		int unsigned i;
		key_side = side_of_len(cfg_len);
		shuffle_rng = SEED_W'(64'(cfg_seed) % 64'h7FFF_FFFF);
		if (shuffle_rng == 0)
			shuffle_rng = 1;
		shuffle_perm(row_key, key_side);
		shuffle_perm(col_key, key_side);
		for (i = 0; i < key_side; i++) begin
			row_unkey[row_key[i]] = i[7:0];
			col_unkey[col_key[i]] = i[7:0];
		end
		keys_ready = 1;
	endtask

	// Apply one accepted transaction; has_res is 0 when no result follows.
	task automatic apply_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
	                             output map_result_t res, output bit has_res);
		int unsigned seq, r, c, pr, pc;
		has_res = 1;
		res = '0;
		if (req == REQ_UNUSED) begin
			has_res = 0;
		end else if (req == REQ_BUILD) begin
			rebuild_keys();
			res.mapped = OUT_W'(key_side * key_side);
		end else if (!keys_ready) begin
			res.status = ST_NOT_BUILT;
		end else begin
			seq = key_side * key_side;
			if (key_side == 0 || idx >= seq) begin
				res.status = ST_RANGE;
			end else begin
				r = idx / key_side;
				c = idx % key_side;
				if (req == REQ_FWD) begin
					pr = row_key[r];
					pc = col_key[c];
				end else begin
					pr = row_unkey[r];
					pc = col_unkey[c];
				end
				res.mapped = OUT_W'(pr * key_side + pc);
			end
		end
	endtask

	// ---------------------------------------------------------------
	// Clock, result sink, checker, watchdog
	// ---------------------------------------------------------------
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver: random stalls, or a long hold that lets the block back up
	initial begin
		rsp_ch.ready <= 0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				rsp_ch.ready <= 0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		map_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_maps.size() == 0) begin
				err_cnt++;
				if (err_cnt <= 10)
					$display("[%0t] unexpected result: mapped=%0d status=%0d",
					         $realtime, rsp_ch.mapped_index, rsp_ch.status);
			end else begin
				want = pending_maps.pop_front();
				if (rsp_ch.mapped_index !== want.mapped || rsp_ch.status !== want.status) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("[%0t] mismatch: exp mapped=%0d status=%0d, got mapped=%0d status=%0d",
						         $realtime, want.mapped, want.status,
						         rsp_ch.mapped_index, rsp_ch.status);
				end
			end
		end
	end

	// counts cycles with no transaction on either channel
	int quiet_cyc;
	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !arst_n)
			quiet_cyc <= 0;
		else
			quiet_cyc <= quiet_cyc + 1;
		if (quiet_cyc >= WDOG_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Driver tasks
	// ---------------------------------------------------------------
	task automatic reg_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
		psel    <= 1;
		penable <= 0;
		pwrite  <= 1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel    <= 0;
		penable <= 0;
		pwrite  <= 0;
		if (addr == REG_FILE_LEN)
			cfg_len = data[LEN_W-1:0];
		else
			cfg_seed = data[SEED_W-1:0];
	endtask

	// stop offering, let every result come home, then give the block time to settle
	task automatic drain();
		req_ch.valid <= 0;
		@(posedge clk);
		while (pending_maps.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic set_keys_cfg(input logic [LEN_W-1:0] len, input logic [SEED_W-1:0] seed);
		drain();
		reg_write(REG_FILE_LEN, DATA_W'(len));
		reg_write(REG_SEED, DATA_W'(seed));
	endtask

	// offer one transaction; valid stays high into the next call unless a gap is drawn
	task automatic send_request(input logic [REQ_W-1:0] req, input logic [IDX_W-1:0] idx,
	                            input bit typed, input map_result_t typed_res);
		map_result_t res;
		bit has_res;
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 0;
			@(posedge clk);
		end
		req_ch.valid      <= 1;
		req_ch.req_type   <= req;
		req_ch.item_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		apply_request(req, idx, res, has_res);
		if (has_res)
			pending_maps.push_back(typed ? typed_res : res);
	endtask

	// ---------------------------------------------------------------
	// Directed table: empty file, saturated side, degenerate seeds,
	// map before build, out-of-range, dropped request code
	// ---------------------------------------------------------------
	dir_row_t dir_tab [N_DIR] = '{
		'{ROW_ITEM, REQ_FWD,    16'h0000, 17'd0,      31'd0,          1, 17'd0,     ST_NOT_BUILT},
		'{ROW_ITEM, REQ_INV,    16'hFFFF, 17'd0,      31'd0,          1, 17'd0,     ST_NOT_BUILT},
		'{ROW_ITEM, REQ_UNUSED, 16'hFFFF, 17'd0,      31'd0,          0, 17'd0,     ST_OK},
		'{ROW_ITEM, REQ_BUILD,  16'h0000, 17'd0,      31'd0,          1, 17'd0,     ST_OK},
		'{ROW_ITEM, REQ_FWD,    16'h0000, 17'd0,      31'd0,          1, 17'd0,     ST_RANGE},
		'{ROW_ITEM, REQ_INV,    16'h1234, 17'd0,      31'd0,          1, 17'd0,     ST_RANGE},
		'{ROW_CFG,  REQ_BUILD,  16'h0000, 17'd65536,  31'h7FFF_FFFF,  0, 17'd0,     ST_OK},
		'{ROW_ITEM, REQ_BUILD,  16'hFFFF, 17'd0,      31'd0,          1, 17'd65536, ST_OK},
		'{ROW_ITEM, REQ_FWD,    16'hFFFF, 17'd0,      31'd0,          0, 17'd0,     ST_OK},
		'{ROW_ITEM, REQ_INV,    16'hFFFF, 17'd0,      31'd0,          0, 17'd0,     ST_OK},
		'{ROW_ITEM, REQ_FWD,    16'h0000, 17'd0,      31'd0,          0, 17'd0,     ST_OK},
		'{ROW_ITEM, REQ_INV,    16'h5AA5, 17'd0,      31'd0,          0, 17'd0,     ST_OK},
		'{ROW_CFG,  REQ_BUILD,  16'h0000, 17'h1FFFF,  31'd0,          0, 17'd0,     ST_OK},
		'{ROW_ITEM, REQ_BUILD,  16'h0000, 17'd0,      31'd0,          1, 17'd65536, ST_OK},
		'{ROW_ITEM, REQ_INV,    16'd12345,17'd0,      31'd0,          0, 17'd0,     ST_OK},
		'{ROW_CFG,  REQ_BUILD,  16'h0000, 17'd1,      31'd12345,      0, 17'd0,     ST_OK},
		'{ROW_ITEM, REQ_BUILD,  16'h0000, 17'd0,      31'd0,          1, 17'd1,     ST_OK},
		'{ROW_ITEM, REQ_FWD,    16'h0000, 17'd0,      31'd0,          1, 17'd0,     ST_OK},
		'{ROW_ITEM, REQ_FWD,    16'h0001, 17'd0,      31'd0,          1, 17'd0,     ST_RANGE},
		'{ROW_CFG,  REQ_BUILD,  16'h0000, 17'd2,      31'd1,          0, 17'd0,     ST_OK},
		'{ROW_ITEM, REQ_BUILD,  16'h0000, 17'd0,      31'd0,          1, 17'd4,     ST_OK},
		'{ROW_ITEM, REQ_FWD,    16'h0003, 17'd0,      31'd0,          0, 17'd0,     ST_OK},
		'{ROW_ITEM, REQ_INV,    16'h0002, 17'd0,      31'd0,          0, 17'd0,     ST_OK},
		'{ROW_CFG,  REQ_BUILD,  16'h0000, 17'd17,     31'd2147483646, 0, 17'd0,     ST_OK},
		'{ROW_ITEM, REQ_BUILD,  16'h0000, 17'd0,      31'd0,          1, 17'd25,    ST_OK},
		'{ROW_ITEM, REQ_INV,    16'd24,   17'd0,      31'd0,          0, 17'd0,     ST_OK},
		'{ROW_ITEM, REQ_FWD,    16'd25,   17'd0,      31'd0,          1, 17'd0,     ST_RANGE},
		'{ROW_ITEM, REQ_UNUSED, 16'h0000, 17'd0,      31'd0,          0, 17'd0,     ST_OK}
	};

	// ---------------------------------------------------------------
	// Main sequence
	// ---------------------------------------------------------------
	initial begin
		map_result_t typed_res;
		logic [REQ_W-1:0] req;
		logic [IDX_W-1:0] idx;
		logic [LEN_W-1:0] len;
		int roll;

		arst_n            <= 0;
		psel              <= 0;
		penable           <= 0;
		pwrite            <= 0;
		paddr             <= '0;
		pwdata            <= '0;
		req_ch.valid      <= 0;
		req_ch.req_type   <= REQ_BUILD;
		req_ch.item_index <= '0;
		src_idle_pct  = 0;
		snk_stall_pct = 0;
		hold_cycles   = 0;
		err_cnt       = 0;
		cfg_len       = '0;
		cfg_seed      = 31'd1;
		key_side      = 0;
		keys_ready    = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				set_keys_cfg(dir_tab[i].len, dir_tab[i].seed);
			end else begin
				typed_res.mapped = dir_tab[i].exp_idx;
				typed_res.status = dir_tab[i].exp_st;
				send_request(dir_tab[i].req, dir_tab[i].idx, dir_tab[i].typed, typed_res);
			end
		end

		// random phases: free flow, slow sender, slow receiver, both
		typed_res = '0;
		for (int ph = 0; ph < N_PHASE; ph++) begin
			// mostly small files keep builds short; empty file now and then
			len = ($urandom_range(9) == 0) ? '0 : LEN_W'($urandom_range(1, 400));
			set_keys_cfg(len, SEED_W'($urandom));
			src_idle_pct  = (ph == 1 || ph == 3) ? ((ph == 1) ? 85 : 33) : 0;
			snk_stall_pct = (ph == 2) ? 85 : ((ph == 3) ? 33 : 0);
			send_request(REQ_BUILD, IDX_W'($urandom), 0, typed_res);
			// long receiver hold while requests keep coming
			if (ph == 0)
				hold_cycles = LONG_HOLD;
			for (int n = 0; n < ITEMS_PHASE; n++) begin
				roll = $urandom_range(99);
				idx  = IDX_W'($urandom);
				if (roll < 3) begin
					req = REQ_BUILD;
				end else if (roll < 6) begin
					req = REQ_UNUSED;
				end else begin
					req = ($urandom_range(1)) ? REQ_FWD : REQ_INV;
					// well-formed maps dominate; the rest keep a full random index
					if (roll >= 14 && key_side != 0)
						idx = IDX_W'($urandom_range(key_side * key_side - 1));
				end
				send_request(req, idx, 0, typed_res);
			end
		end

		drain();
		if (err_cnt == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire
